// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the response line matcher.
// Depends on a clock named clock and an active-high synchronous reset named reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// check a property outside reset
`define ASSERT_CLK(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");

// check a property on every edge, reset included
`define ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("assertion failed");

`else

`define ASSERT_CLK(label, prop)
`define ASSERT_ALWAYS(label, prop)

`endif

`endif

// ===== hdl/mrlm_pkg.sv =====
// Package for the modem response line matcher: codes, characters and limits.
// Used by modem_response_line_matcher; depends on nothing.
package mrlm_pkg;

   localparam int LINE_MAX   = 512;
   localparam int PREFIX_MAX = 16;

   localparam int COUNT_W = 10;
   localparam int RETRY_W = 20;
   localparam int PLEN_W  = 5;

   localparam logic [1:0] OP_ARM  = 2'd0;
   localparam logic [1:0] OP_BYTE = 2'd1;
   localparam logic [1:0] OP_POLL = 2'd2;

   localparam logic [2:0] ST_WAIT     = 3'd0;
   localparam logic [2:0] ST_MATCH    = 3'd1;
   localparam logic [2:0] ST_ERROR    = 3'd2;
   localparam logic [2:0] ST_DISCARD  = 3'd3;
   localparam logic [2:0] ST_TIMEOUT  = 3'd4;
   localparam logic [2:0] ST_TOO_LONG = 3'd5;
   localparam logic [2:0] ST_IDLE     = 3'd6;

   localparam logic [2:0] REG_PREFIX_LOW  = 3'd0;
   localparam logic [2:0] REG_PREFIX_HIGH = 3'd1;
   localparam logic [2:0] REG_PREFIX_LEN  = 3'd2;
   localparam logic [2:0] REG_RETRY_LIMIT = 3'd3;
   localparam logic [2:0] REG_LINE_CAP    = 3'd4;

   localparam logic [7:0]  CH_NUL     = 8'h00;
   localparam logic [7:0]  CH_CR      = 8'h0D;
   localparam logic [7:0]  CH_LF      = 8'h0A;
   localparam logic [39:0] ERROR_WORD = 40'h45_52_52_4F_52;

   localparam logic [RETRY_W-1:0] RETRY_LIMIT_RESET = RETRY_W'(1000);
   localparam logic [COUNT_W-1:0] LINE_CAP_RESET    = COUNT_W'(LINE_MAX);

   typedef logic [2:0] status_type;

endpackage

// ===== hdl/modem_response_line_matcher.sv =====
// Modem response line matcher: takes one item per clock and returns one result
// item per item. The item is held in an input register, the whole step is
// worked out in one pass of compares and counter updates against the wait
// state, and the result lands in an output register, so a new item is taken
// every cycle while the result side keeps up.
// Configuration is a 64-bit register port at byte addresses 0, 8, 16, 24, 32.
// Depends on mrlm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module modem_response_line_matcher
   import mrlm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic [1:0]  req_tuser,   // [1:0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [2:0] status, [12:3] line_length, [20:13] kept_byte
   output logic        rsp_tuser,   // [0] byte_kept
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   logic [63:0]        prefix_low_ff;
   logic [63:0]        prefix_high_ff;
   logic [PLEN_W-1:0]  prefix_len_ff;
   logic [RETRY_W-1:0] retry_limit_ff;
   logic [COUNT_W-1:0] line_cap_ff;

   logic       s1_valid_ff;
   logic [1:0] s1_op_ff;
   logic [7:0] s1_byte_ff;

   logic               armed_ff, armed_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [RETRY_W-1:0] retry_ff, retry_in;
   logic               mismatch_ff, mismatch_in;
   logic [39:0]        recent_ff, recent_in;
   logic               err_seen_ff, err_seen_in;

   logic               out_valid_ff;
   status_type         out_status_ff, status_in;
   logic [COUNT_W-1:0] out_len_ff;
   logic               out_kept_ff, kept_in;
   logic [7:0]         out_byte_ff, kbyte_in;

   logic               advance;
   logic               cfg_write;
   logic [2:0]         cfg_index;
   logic [127:0]       prefix_all;
   logic [7:0]         prefix_chr [PREFIX_MAX];
   logic [PLEN_W-1:0]  plen_sat;
   logic [PLEN_W-1:0]  first_zero;
   logic [PLEN_W-1:0]  plen_eff;
   logic [COUNT_W-1:0] cap_eff;
   logic [RETRY_W-1:0] retry_bump;
   logic               do_check;

   assign csr_pready = 1'b1;
   assign cfg_index  = csr_paddr[5:3];
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_low_ff  <= '0;
         prefix_high_ff <= '0;
         prefix_len_ff  <= '0;
         retry_limit_ff <= RETRY_LIMIT_RESET;
         line_cap_ff    <= LINE_CAP_RESET;
      end else if (cfg_write) begin
         unique case (cfg_index)
            REG_PREFIX_LOW:  prefix_low_ff  <= csr_pwdata;
            REG_PREFIX_HIGH: prefix_high_ff <= csr_pwdata;
            REG_PREFIX_LEN:  prefix_len_ff  <= csr_pwdata[PLEN_W-1:0];
            REG_RETRY_LIMIT: retry_limit_ff <= csr_pwdata[RETRY_W-1:0];
            REG_LINE_CAP:    line_cap_ff    <= csr_pwdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (cfg_index)
         REG_PREFIX_LOW:  csr_prdata = prefix_low_ff;
         REG_PREFIX_HIGH: csr_prdata = prefix_high_ff;
         REG_PREFIX_LEN:  csr_prdata = 64'(prefix_len_ff);
         REG_RETRY_LIMIT: csr_prdata = 64'(retry_limit_ff);
         REG_LINE_CAP:    csr_prdata = 64'(line_cap_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // effective prefix length and capacity
   assign prefix_all = {prefix_high_ff, prefix_low_ff};

   always_comb begin
      first_zero = PLEN_W'(PREFIX_MAX);
      for (int i = PREFIX_MAX - 1; i >= 0; i--) begin
         prefix_chr[i] = prefix_all[8*i +: 8];
         if (prefix_chr[i] == CH_NUL) begin
            first_zero = PLEN_W'(i);
         end
      end
   end

   assign plen_sat = (prefix_len_ff > PLEN_W'(PREFIX_MAX)) ? PLEN_W'(PREFIX_MAX) : prefix_len_ff;
   assign plen_eff = (first_zero < plen_sat) ? first_zero : plen_sat;
   assign cap_eff  = (line_cap_ff > COUNT_W'(LINE_MAX)) ? COUNT_W'(LINE_MAX) : line_cap_ff;

   // handshake
   assign advance    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_op_ff   <= req_tuser;
         s1_byte_ff <= req_tdata;
      end
   end

   // one step of the wait
   assign retry_bump = (retry_ff != '1) ? retry_ff + RETRY_W'(1) : retry_ff;

   always_comb begin
      armed_in    = armed_ff;
      count_in    = count_ff;
      retry_in    = retry_ff;
      mismatch_in = mismatch_ff;
      recent_in   = recent_ff;
      err_seen_in = err_seen_ff;
      status_in   = ST_WAIT;
      kept_in     = 1'b0;
      kbyte_in    = '0;
      do_check    = 1'b0;

      priority if (s1_op_ff == OP_ARM) begin
         armed_in    = 1'b1;
         retry_in    = '0;
         count_in    = '0;
         mismatch_in = 1'b0;
         recent_in   = '0;
         err_seen_in = 1'b0;
         do_check    = 1'b1;
      end else if (!armed_ff) begin
         status_in = ST_IDLE;
      end else if (s1_op_ff == OP_POLL || s1_op_ff == OP_BYTE) begin
         priority if (s1_op_ff == OP_POLL || s1_byte_ff == CH_NUL) begin
            retry_in = retry_bump;
         end else if (s1_byte_ff == CH_CR) begin
         end else if (s1_byte_ff == CH_LF) begin
            priority if (count_ff == '0) begin
               retry_in = retry_bump;
            end else if (!mismatch_ff && count_ff >= COUNT_W'(plen_eff)) begin
               armed_in  = 1'b0;
               status_in = ST_MATCH;
            end else if (err_seen_ff) begin
               armed_in  = 1'b0;
               status_in = ST_ERROR;
            end else begin
               count_in    = '0;
               mismatch_in = 1'b0;
               recent_in   = '0;
               err_seen_in = 1'b0;
               retry_in    = retry_bump;
               status_in   = ST_DISCARD;
            end
         end else begin
            if (count_ff < COUNT_W'(plen_eff) && prefix_chr[count_ff[3:0]] != s1_byte_ff) begin
               mismatch_in = 1'b1;
            end
            recent_in = {recent_ff[31:0], s1_byte_ff};
            if (recent_in == ERROR_WORD) begin
               err_seen_in = 1'b1;
            end
            count_in = count_ff + COUNT_W'(1);
            kept_in  = 1'b1;
            kbyte_in = s1_byte_ff;
         end
         do_check = armed_in;
      end else begin
         status_in = ST_WAIT;
      end

      if (do_check) begin
         priority if (retry_in >= retry_limit_ff) begin
            armed_in  = 1'b0;
            status_in = ST_TIMEOUT;
         end else if (count_in >= cap_eff) begin
            armed_in  = 1'b0;
            status_in = ST_TOO_LONG;
         end else begin
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff    <= 1'b0;
         count_ff    <= '0;
         retry_ff    <= '0;
         mismatch_ff <= 1'b0;
         recent_ff   <= '0;
         err_seen_ff <= 1'b0;
      end else if (advance) begin
         armed_ff    <= armed_in;
         count_ff    <= count_in;
         retry_ff    <= retry_in;
         mismatch_ff <= mismatch_in;
         recent_ff   <= recent_in;
         err_seen_ff <= err_seen_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_status_ff <= status_in;
         out_len_ff    <= count_in;
         out_kept_ff   <= kept_in;
         out_byte_ff   <= kbyte_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_byte_ff, out_len_ff, out_status_ff};
   assign rsp_tuser  = out_kept_ff;

   `ASSERT_CLK(a_count_bounded, armed_ff |-> count_ff <= COUNT_W'(LINE_MAX))
   `ASSERT_CLK(a_match_disarms, advance && status_in == ST_MATCH |=> !armed_ff)
   `ASSERT_CLK(a_kept_while_waiting, out_valid_ff && out_kept_ff |-> out_status_ff != ST_IDLE)
   `ASSERT_ALWAYS(a_empty_after_reset, reset |=> !rsp_tvalid)

endmodule
